// File: rtl/dlts_pkg.sv
// Package for the delta-list task scheduler.
// Holds widths, operation and status codes and the table entry type.
// No dependencies.
`default_nettype none

package dlts_pkg;

  localparam int MAX_TASKS = 16;
  localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);

  localparam int FUNC_W    = 2;
  localparam int TASK_W    = 8;
  localparam int DELTA_W   = 32;
  localparam int RUNS_W    = 8;
  localparam int SIDX_W    = 8;
  localparam int PLACED_W  = 8;
  localparam int STAT_W    = 2;
  localparam int SCMP_W    = SIDX_W + 1;

  localparam logic [RUNS_W-1:0] RUNS_MAX = '1;

  localparam logic [FUNC_W-1:0] FN_TICK = 2'd0;
  localparam logic [FUNC_W-1:0] FN_ADD  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_DEL  = 2'd2;
  localparam logic [FUNC_W-1:0] FN_DISP = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [TASK_W-1:0]  task_id;
    logic [DELTA_W-1:0] delta;
    logic [DELTA_W-1:0] period;
    logic [RUNS_W-1:0]  runs;
  } entry_t;

endpackage

`default_nettype wire

// File: rtl/dlts_if.sv
// Handshake channels of the delta-list task scheduler: command in, result out.
// Depends on dlts_pkg.
`default_nettype none

interface dlts_in_if import dlts_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [TASK_W-1:0]   task_id;
  logic [DELTA_W-1:0]  delay;
  logic [DELTA_W-1:0]  period;
  logic [SIDX_W-1:0]   slot_index;

  modport source (output valid, func, task_id, delay, period, slot_index, input ready);
  modport sink   (input valid, func, task_id, delay, period, slot_index, output ready);
endinterface

interface dlts_out_if import dlts_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                run_valid;
  logic [TASK_W-1:0]   run_task;
  logic [PLACED_W-1:0] placed_slot;
  logic [STAT_W-1:0]   status;

  modport source (output valid, run_valid, run_task, placed_slot, status, input ready);
  modport sink   (input valid, run_valid, run_task, placed_slot, status, output ready);
endinterface

`default_nettype wire

// File: rtl/delta_list_task_scheduler.sv
// Delta-list task scheduler: sorted table of tasks with relative delays.
// Commands run one at a time, paced by the table's single read port, which a
// sequencer steps one slot per cycle past the shared adder; a new command is
// taken only in idle, once the last one has moved its result out.
// A finished result sits in an output register while the next item is taken.
// Reset (async, active low) empties the table via the fill count; no clearing pass.
`default_nettype none

module delta_list_task_scheduler import dlts_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dlts_in_if.sink    in_i,
  dlts_out_if.source out_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TICK  = 4'd1;
  localparam logic [3:0] S_WALK  = 4'd2;
  localparam logic [3:0] S_SHIFT = 4'd3;
  localparam logic [3:0] S_INS   = 4'd4;
  localparam logic [3:0] S_DLOAD = 4'd5;
  localparam logic [3:0] S_DCOPY = 4'd6;
  localparam logic [3:0] S_DISP  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]          state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                readd_q, readd_d;
  logic                fold_q, fold_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [IDX_W-1:0]    j_q, j_d;
  logic [DELTA_W-1:0]  dly_q, dly_d;
  logic [DELTA_W-1:0]  per_q, per_d;
  logic [TASK_W-1:0]   id_q, id_d;

  logic                res_run_valid_q, res_run_valid_d;
  logic [TASK_W-1:0]   res_run_task_q, res_run_task_d;
  logic [PLACED_W-1:0] res_placed_q, res_placed_d;
  logic [STAT_W-1:0]   res_status_q, res_status_d;

  logic                out_valid_q;
  logic                out_run_valid_q;
  logic [TASK_W-1:0]   out_run_task_q;
  logic [PLACED_W-1:0] out_placed_q;
  logic [STAT_W-1:0]   out_status_q;
  logic                out_load;

  logic                accept;
  logic                we;
  logic [IDX_W-1:0]    waddr, rd_addr;
  entry_t              wdata, rdata;
  logic [DELTA_W-1:0]  alu_a, alu_b, alu_res;
  logic                alu_sub, alu_nb;

  logic                del_begin, del_end, add_begin;
  logic [CNT_W-1:0]    add_cnt;
  logic [CNT_W-1:0]    idx_nxt;
  logic [IDX_W-1:0]    top_slot, jm1;
  logic                full;

  dlts_table u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  dlts_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .res_o (alu_res),
    .nb_o  (alu_nb)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && (state_q == S_IDLE);
  assign full       = (cnt_q == CNT_W'(MAX_TASKS));
  assign idx_nxt    = CNT_W'(idx_q) + CNT_W'(1);
  assign top_slot   = full ? IDX_W'(MAX_TASKS - 1) : cnt_q[IDX_W-1:0];
  assign jm1        = j_q - IDX_W'(1);

  always_comb begin
    state_d         = state_q;
    cnt_d           = cnt_q;
    readd_d         = readd_q;
    fold_d          = fold_q;
    idx_d           = idx_q;
    j_d             = j_q;
    dly_d           = dly_q;
    per_d           = per_q;
    id_d            = id_q;
    res_run_valid_d = res_run_valid_q;
    res_run_task_d  = res_run_task_q;
    res_placed_d    = res_placed_q;
    res_status_d    = res_status_q;
    out_load        = 1'b0;
    we              = 1'b0;
    waddr           = idx_q;
    wdata           = rdata;
    rd_addr         = '0;
    alu_a           = dly_q;
    alu_b           = rdata.delta;
    alu_sub         = 1'b1;
    del_begin       = 1'b0;
    del_end         = 1'b0;
    add_begin       = 1'b0;
    add_cnt         = cnt_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_run_valid_d = 1'b0;
          res_run_task_d  = '0;
          res_placed_d    = '0;
          res_status_d    = ST_OK;
          readd_d         = 1'b0;
          idx_d           = '0;
          unique case (in_i.func)
            FN_TICK: begin
              state_d = (cnt_q == '0) ? S_DONE : S_TICK;
            end
            FN_ADD: begin
              id_d         = in_i.task_id;
              dly_d        = in_i.delay;
              per_d        = in_i.period;
              res_status_d = full ? ST_FULL : ST_OK;
              add_begin    = 1'b1;
            end
            FN_DEL: begin
              if ({1'b0, in_i.slot_index} >= SCMP_W'(MAX_TASKS)) begin
                res_status_d = ST_RANGE;
                state_d      = S_DONE;
              end else if ({1'b0, in_i.slot_index} >= SCMP_W'(cnt_q)) begin
                state_d = S_DONE;
              end else begin
                idx_d   = in_i.slot_index[IDX_W-1:0];
                rd_addr = in_i.slot_index[IDX_W-1:0];
                state_d = S_DLOAD;
              end
            end
            FN_DISP: begin
              state_d = (cnt_q == '0) ? S_DONE : S_DISP;
            end
          endcase
        end
      end
      S_TICK: begin
        we      = 1'b1;
        waddr   = '0;
        alu_a   = rdata.delta;
        alu_b   = DELTA_W'(1);
        if (rdata.delta == '0) begin
          wdata.runs = (rdata.runs == RUNS_MAX) ? rdata.runs : rdata.runs + RUNS_W'(1);
        end else begin
          wdata.delta = alu_res;
        end
        state_d = S_DONE;
      end
      S_WALK: begin
        // remaining delay against this slot's delta
        if (alu_nb) begin
          dly_d = alu_res;
          if (idx_nxt == cnt_q) begin
            if (full) begin
              state_d = S_DONE;
            end else begin
              idx_d   = IDX_W'(idx_nxt);
              state_d = S_INS;
            end
          end else begin
            idx_d   = IDX_W'(idx_nxt);
            rd_addr = IDX_W'(idx_nxt);
          end
        end else if (top_slot == idx_q) begin
          state_d = S_INS;
        end else begin
          j_d     = top_slot;
          rd_addr = top_slot - IDX_W'(1);
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        we      = 1'b1;
        waddr   = j_q;
        alu_a   = rdata.delta;
        alu_b   = dly_q;
        if (jm1 == idx_q) begin
          wdata.delta = alu_res;
          state_d     = S_INS;
        end else begin
          j_d     = jm1;
          rd_addr = jm1 - IDX_W'(1);
        end
      end
      S_INS: begin
        we            = 1'b1;
        waddr         = idx_q;
        wdata.task_id = id_q;
        wdata.delta   = dly_q;
        wdata.period  = per_q;
        wdata.runs    = '0;
        cnt_d         = full ? cnt_q : cnt_q + CNT_W'(1);
        res_placed_d  = PLACED_W'(idx_q);
        state_d       = S_DONE;
      end
      S_DLOAD: begin
        del_begin = 1'b1;
      end
      S_DCOPY: begin
        we      = 1'b1;
        waddr   = idx_q;
        alu_a   = rdata.delta;
        alu_b   = dly_q;
        alu_sub = 1'b0;
        if (fold_q) begin
          wdata.delta = alu_res;
        end
        fold_d = 1'b0;
        if (CNT_W'(idx_q) + CNT_W'(2) == cnt_q) begin
          del_end = 1'b1;
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          rd_addr = idx_q + IDX_W'(2);
        end
      end
      S_DISP: begin
        if (rdata.runs != '0) begin
          res_run_valid_d = 1'b1;
          res_run_task_d  = rdata.task_id;
          id_d            = rdata.task_id;
          per_d           = rdata.period;
          readd_d         = (rdata.period != '0);
          del_begin       = 1'b1;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // removal of slot idx_q, whose entry is on the read port
    if (del_begin) begin
      dly_d  = rdata.delta;
      fold_d = 1'b1;
      if (idx_nxt == cnt_q) begin
        del_end = 1'b1;
      end else begin
        rd_addr = IDX_W'(idx_nxt);
        state_d = S_DCOPY;
      end
    end

    if (del_end) begin
      cnt_d = cnt_q - CNT_W'(1);
      if (readd_d) begin
        dly_d     = per_d;
        add_cnt   = cnt_d;
        add_begin = 1'b1;
      end else begin
        state_d = S_DONE;
      end
    end

    if (add_begin) begin
      idx_d = '0;
      if (add_cnt == '0) begin
        state_d = S_INS;
      end else begin
        rd_addr = '0;
        state_d = S_WALK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      readd_q     <= 1'b0;
      fold_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      readd_q <= readd_d;
      fold_q  <= fold_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q           <= idx_d;
    j_q             <= j_d;
    dly_q           <= dly_d;
    per_q           <= per_d;
    id_q            <= id_d;
    res_run_valid_q <= res_run_valid_d;
    res_run_task_q  <= res_run_task_d;
    res_placed_q    <= res_placed_d;
    res_status_q    <= res_status_d;
    if (out_load) begin
      out_run_valid_q <= res_run_valid_q;
      out_run_task_q  <= res_run_task_q;
      out_placed_q    <= res_placed_q;
      out_status_q    <= res_status_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.run_valid   = out_run_valid_q;
  assign out_o.run_task    = out_run_task_q;
  assign out_o.placed_slot = out_placed_q;
  assign out_o.status      = out_status_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_TASKS))
    else $error("task count above table size");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |->
      ((cnt_q == $past(cnt_q) + CNT_W'(1)) || (cnt_q == $past(cnt_q) - CNT_W'(1))))
    else $error("task count moved by more than one");

  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> ((state_q != S_IDLE) && (state_q != S_DONE)))
    else $error("table written outside an operation");

  a_idle_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.run_valid) |-> (out_o.run_task == '0))
    else $error("run task set without a released item");

endmodule

`default_nettype wire

// File: rtl/dlts_alu.sv
// Shared 32-bit add/subtract unit of the scheduler; no-borrow flag gives a >= b.
// Depends on dlts_pkg.
`default_nettype none

module dlts_alu import dlts_pkg::*; (
  input  wire logic [DELTA_W-1:0] a_i,
  input  wire logic [DELTA_W-1:0] b_i,
  input  wire logic               sub_i,
  output logic      [DELTA_W-1:0] res_o,
  output logic                    nb_o
);

  logic [DELTA_W:0] sum;

  assign sum   = {1'b0, a_i} + {1'b0, b_i ^ {DELTA_W{sub_i}}} + {{DELTA_W{1'b0}}, sub_i};
  assign res_o = sum[DELTA_W-1:0];
  assign nb_o  = sum[DELTA_W];

endmodule

`default_nettype wire

// File: rtl/dlts_table.sv
// Task table storage: one write port, one registered read port.
// A read of the slot being written returns the new entry.
// Depends on dlts_pkg.
`default_nettype none

module dlts_table import dlts_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [IDX_W-1:0] waddr_i,
  input  wire entry_t           wdata_i,
  input  wire logic [IDX_W-1:0] raddr_i,
  output entry_t                rdata_o
);

  entry_t mem_q [MAX_TASKS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_o <= wdata_i;
    end else begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: tb/dlts_schedule_checker.sv
// Result checker for the delta-list task scheduler: mirrors the task table,
// predicts the result of every accepted command and compares the results that come out.
// Depends on dlts_pkg and the channel interfaces in dlts_if.
`timescale 1ns / 1ps

module dlts_schedule_checker import dlts_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  dlts_in_if   cmd_i,
  dlts_out_if  res_i,
  output int   mismatch_cnt_o,
  output int   awaiting_o
);

  typedef struct packed {
    logic                run_valid;
    logic [TASK_W-1:0]   run_task;
    logic [PLACED_W-1:0] placed_slot;
    logic [STAT_W-1:0]   status;
  } outcome_t;

  logic               tbl_used   [MAX_TASKS];
  logic [TASK_W-1:0]  tbl_task   [MAX_TASKS];
  logic [DELTA_W-1:0] tbl_delta  [MAX_TASKS];
  logic [DELTA_W-1:0] tbl_period [MAX_TASKS];
  logic [RUNS_W-1:0]  tbl_runs   [MAX_TASKS];

  outcome_t due_outcomes[$];
  int       mismatches = 0;

  assign mismatch_cnt_o = mismatches;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  function automatic void move_entry(input int dst, input int src);
    tbl_used[dst]   = tbl_used[src];
    tbl_task[dst]   = tbl_task[src];
    tbl_delta[dst]  = tbl_delta[src];
    tbl_period[dst] = tbl_period[src];
    tbl_runs[dst]   = tbl_runs[src];
  endfunction

  function automatic void clear_entry(input int pos);
    tbl_used[pos]   = 1'b0;
    tbl_task[pos]   = '0;
    tbl_delta[pos]  = '0;
    tbl_period[pos] = '0;
    tbl_runs[pos]   = '0;
  endfunction

  // Walk past every entry due no later than the new one; on a full table the
  // last entry falls off, or the new task itself when it sorts last.
  function automatic void insert_task(input logic [TASK_W-1:0] id,
                                      input logic [DELTA_W-1:0] dly,
                                      input logic [DELTA_W-1:0] per,
                                      output logic [PLACED_W-1:0] placed,
                                      output logic [STAT_W-1:0] status);
    int                 pos;
    logic [DELTA_W-1:0] rest;
    status = tbl_used[MAX_TASKS-1] ? ST_FULL : ST_OK;
    placed = '0;
    rest   = dly;
    pos    = 0;
    while (pos < MAX_TASKS && tbl_used[pos] && rest >= tbl_delta[pos]) begin
      rest -= tbl_delta[pos];
      pos++;
    end
    if (pos < MAX_TASKS) begin
      for (int j = MAX_TASKS - 1; j > pos; j--) move_entry(j, j - 1);
      tbl_used[pos]   = 1'b1;
      tbl_task[pos]   = id;
      tbl_delta[pos]  = rest;
      tbl_period[pos] = per;
      tbl_runs[pos]   = '0;
      if (pos + 1 < MAX_TASKS && tbl_used[pos + 1]) tbl_delta[pos + 1] -= rest;
      placed = PLACED_W'(pos);
    end
  endfunction

  // Later due times stay put: the removed delta folds into the next entry.
  function automatic void remove_slot(input int idx);
    if (idx + 1 < MAX_TASKS && tbl_used[idx + 1]) tbl_delta[idx + 1] += tbl_delta[idx];
    for (int j = idx; j + 1 < MAX_TASKS; j++) move_entry(j, j + 1);
    clear_entry(MAX_TASKS - 1);
  endfunction

  function automatic outcome_t sched_outcome(input logic [FUNC_W-1:0] fn,
                                             input logic [TASK_W-1:0] id,
                                             input logic [DELTA_W-1:0] dly,
                                             input logic [DELTA_W-1:0] per,
                                             input logic [SIDX_W-1:0] idx);
    outcome_t           res;
    logic [TASK_W-1:0]  head_id;
    logic [DELTA_W-1:0] head_per;
    logic [STAT_W-1:0]  readd_status;
    res = '0;
    case (fn)
      FN_TICK: begin
        if (tbl_used[0]) begin
          if (tbl_delta[0] == '0) begin
            if (tbl_runs[0] != RUNS_MAX) tbl_runs[0]++;
          end else begin
            tbl_delta[0]--;
          end
        end
      end
      FN_ADD: begin
        insert_task(id, dly, per, res.placed_slot, res.status);
      end
      FN_DEL: begin
        if (idx >= MAX_TASKS) res.status = ST_RANGE;
        else remove_slot(int'(idx));
      end
      FN_DISP: begin
        if (tbl_used[0] && tbl_runs[0] != '0) begin
          head_id       = tbl_task[0];
          head_per      = tbl_period[0];
          res.run_valid = 1'b1;
          res.run_task  = head_id;
          remove_slot(0);
          // periodic head comes back one period out, pending runs dropped
          if (head_per != '0) insert_task(head_id, head_per, head_per, res.placed_slot,
                                          readd_status);
        end
      end
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t seen;
    outcome_t want;
    if (!rst_ni) begin
      for (int k = 0; k < MAX_TASKS; k++) clear_entry(k);
      due_outcomes.delete();
      awaiting_o <= 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        seen.run_valid   = res_i.run_valid;
        seen.run_task    = res_i.run_task;
        seen.placed_slot = res_i.placed_slot;
        seen.status      = res_i.status;
        if (due_outcomes.size() == 0) begin
          report_mismatch("unexpected result", 32'(seen), '0);
        end else begin
          want = due_outcomes.pop_front();
          if (seen.run_valid !== want.run_valid)
            report_mismatch("run_valid", 32'(seen.run_valid), 32'(want.run_valid));
          if (seen.run_task !== want.run_task)
            report_mismatch("run_task", 32'(seen.run_task), 32'(want.run_task));
          if (seen.placed_slot !== want.placed_slot)
            report_mismatch("placed_slot", 32'(seen.placed_slot), 32'(want.placed_slot));
          if (seen.status !== want.status)
            report_mismatch("status", 32'(seen.status), 32'(want.status));
        end
      end
      if (cmd_i.valid && cmd_i.ready)
        due_outcomes.push_back(sched_outcome(cmd_i.func, cmd_i.task_id, cmd_i.delay,
                                             cmd_i.period, cmd_i.slot_index));
      awaiting_o <= due_outcomes.size();
    end
  end

endmodule

// File: tb/delta_list_task_scheduler_test.sv
// Testbench top for the delta-list task scheduler: clock, reset, command stimulus,
// result back-pressure, watchdog and verdict; checking sits in dlts_schedule_checker.
// Depends on dlts_pkg, dlts_if, delta_list_task_scheduler and dlts_schedule_checker.
`timescale 1ns / 1ps

module delta_list_task_scheduler_test;
  import dlts_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 3 * MAX_TASKS + 8;
  localparam int LONG_HOLD      = 300;
  localparam int PHASE_ITEMS    = 430;

  logic clk_i;
  logic rst_ni;
  int   fails;
  int   awaiting;
  int   snd_idle_pct = 38;
  int   rcv_idle_pct = 56;
  logic hold_armed   = 1'b0;
  int   quiet_cycles = 0;
  int   sent         = 0;

  dlts_in_if  cmd_if ();
  dlts_out_if res_if ();

  delta_list_task_scheduler i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  dlts_schedule_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd_if),
    .res_i          (res_if),
    .mismatch_cnt_o (fails),
    .awaiting_o     (awaiting)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Result side: random stalls, plus one long hold-off once armed.
  initial begin : result_sink
    int hold_left;
    bit hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_armed && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("delta_list_task_scheduler_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Valid stays high into the next item unless a gap is rolled.
  task automatic send_cmd(input logic [FUNC_W-1:0] fn, input logic [TASK_W-1:0] id,
                          input logic [DELTA_W-1:0] dly, input logic [DELTA_W-1:0] per,
                          input logic [SIDX_W-1:0] idx);
    if ($urandom_range(99) < snd_idle_pct) begin
      cmd_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < snd_idle_pct);
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.func       <= fn;
    cmd_if.task_id    <= id;
    cmd_if.delay      <= dly;
    cmd_if.period     <= per;
    cmd_if.slot_index <= idx;
    do @(posedge clk_i); while (cmd_if.ready !== 1'b1);
    sent++;
  endtask

  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    do @(posedge clk_i); while (awaiting != 0);
  endtask

  // Mostly small delays and periods so heads come due; now and then full-width values.
  task automatic send_random_cmd();
    int                 pick;
    logic [FUNC_W-1:0]  fn;
    logic [DELTA_W-1:0] dly;
    logic [DELTA_W-1:0] per;
    logic [SIDX_W-1:0]  idx;
    pick = $urandom_range(99);
    if (pick < 38) fn = FN_TICK;
    else if (pick < 63) fn = FN_ADD;
    else if (pick < 75) fn = FN_DEL;
    else fn = FN_DISP;
    dly = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(12);
    if ($urandom_range(2) == 0) per = '0;
    else per = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(1, 10);
    idx = SIDX_W'(($urandom_range(7) == 0) ? $urandom_range(255)
                                           : $urandom_range(MAX_TASKS));
    send_cmd(fn, TASK_W'($urandom_range(255)), dly, per, idx);
  endtask

  initial begin : stimulus
    int phase;
    int phase_start;
    int phase_end;
    int roll;
    bit burst_done;
    burst_done = 1'b0;
    rst_ni = 1'b0;
    cmd_if.valid      <= 1'b0;
    cmd_if.func       <= FN_TICK;
    cmd_if.task_id    <= '0;
    cmd_if.delay      <= '0;
    cmd_if.period     <= '0;
    cmd_if.slot_index <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty table corners
    send_cmd(FN_TICK, '0, '0, '0, '0);
    send_cmd(FN_DISP, '0, '0, '0, '0);
    send_cmd(FN_DEL, '0, '0, '0, 8'd3);
    send_cmd(FN_DEL, '0, '0, '0, SIDX_W'(MAX_TASKS));
    send_cmd(FN_DEL, '0, '0, '0, '1);
    send_cmd(FN_DEL, '0, '0, '0, SIDX_W'(MAX_TASKS - 1));
    // one-shot: dispatch before and after its runs build up
    send_cmd(FN_ADD, '1, '0, '0, '0);
    send_cmd(FN_DISP, '0, '0, '0, '0);
    send_cmd(FN_TICK, '0, '0, '0, '0);
    send_cmd(FN_TICK, '0, '0, '0, '0);
    send_cmd(FN_DISP, '0, '0, '0, '0);
    // insert ahead of an occupied slot, at the tail, then fold a delete
    send_cmd(FN_ADD, 8'h00, 32'd3, 32'd2, '0);
    send_cmd(FN_ADD, 8'h11, 32'd1, '0, '0);
    send_cmd(FN_ADD, 8'h22, '1, '1, '0);
    send_cmd(FN_DEL, '0, '0, '0, '0);
    // bring the periodic head due and release it
    repeat (4) send_cmd(FN_TICK, '0, '0, '0, '0);
    send_cmd(FN_DISP, '0, '0, '0, '0);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          snd_idle_pct = 38;
          rcv_idle_pct = 56;
        end
        1: begin
          snd_idle_pct = 56;
          rcv_idle_pct = 38;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      phase_start = sent;
      phase_end   = sent + PHASE_ITEMS;
      while (sent < phase_end) begin
        if (phase == 2 && !hold_armed && sent - phase_start > 40) hold_armed <= 1'b1;
        roll = $urandom_range(99);
        if (phase == 2 && !burst_done && sent - phase_start > 200) begin
          // drive the head's run count into saturation
          burst_done = 1'b1;
          send_cmd(FN_ADD, TASK_W'($urandom_range(255)), '0, '0, '0);
          repeat (270) send_cmd(FN_TICK, '0, '0, '0, '0);
          send_cmd(FN_DISP, '0, '0, '0, '0);
        end else if (roll < 4) begin
          // fill to overflow, including a task that sorts after everything
          repeat (MAX_TASKS + 2)
            send_cmd(FN_ADD, TASK_W'($urandom_range(255)), $urandom_range(20),
                     ($urandom_range(1) == 0) ? '0 : $urandom_range(1, 8), '0);
          send_cmd(FN_ADD, TASK_W'($urandom_range(255)), '1, '0, '0);
        end else if (roll < 7) begin
          wait_drained();
        end else begin
          send_random_cmd();
        end
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fails == 0 && awaiting == 0) begin
      $display("delta_list_task_scheduler_test OK");
    end else begin
      $display("delta_list_task_scheduler_test NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/dlts_pkg.sv
rtl/dlts_if.sv
rtl/dlts_alu.sv
rtl/dlts_table.sv
rtl/delta_list_task_scheduler.sv
tb/dlts_schedule_checker.sv
tb/delta_list_task_scheduler_test.sv
